@@ rtl/core/kcl_pkg.sv @@
// Shared types, codes and constants for the keypad combination lock.
package kcl_pkg;

	localparam int STORE_DEPTH_DEF = 62;
	localparam int MASTER_LEN_DEF  = 8;
	localparam int ADDR_W          = 8;	// wide enough for any store depth in range

	localparam logic [3:0] ERASED_DIGIT = 4'd15;
	localparam logic [3:0] KEY_STAR     = 4'd10;
	localparam logic [3:0] KEY_HASH     = 4'd11;
	localparam logic [3:0] DIGIT_LIMIT  = 4'd10;
	localparam logic [7:0] IDLE_LOW_MAX = 8'd255;

	localparam logic [1:0] OP_TICK    = 2'd0;
	localparam logic [1:0] OP_PRESS   = 2'd1;
	localparam logic [1:0] OP_RELEASE = 2'd2;

	localparam logic [2:0] CFG_WRONG_TICKS = 3'd0;
	localparam logic [2:0] CFG_BUZZ_TICKS  = 3'd1;
	localparam logic [2:0] CFG_LOCK_TICKS  = 3'd2;
	localparam logic [2:0] CFG_IDLE_LIMIT  = 3'd3;
	localparam logic [2:0] CFG_CHG_PRESSES = 3'd4;
	localparam logic [2:0] CFG_MASTER_CODE = 3'd5;

	localparam logic [7:0]  RST_WRONG_TICKS = 8'd30;
	localparam logic [7:0]  RST_BUZZ_TICKS  = 8'd15;
	localparam logic [7:0]  RST_LOCK_TICKS  = 8'd45;
	localparam logic [7:0]  RST_IDLE_LIMIT  = 8'd4;
	localparam logic [7:0]  RST_CHG_PRESSES = 8'd3;
	localparam logic [31:0] RST_MASTER_CODE = 32'h7293_7054;

	typedef struct packed {
		logic [7:0]  wrong_ticks;
		logic [7:0]  buzzer_ticks;
		logic [7:0]  lock_ticks;
		logic [7:0]  idle_limit;
		logic [7:0]  change_presses;
		logic [31:0] master_code;
	} cfg_t;

	typedef struct packed {
		logic              we;
		logic [ADDR_W-1:0] waddr;
		logic [3:0]        wdata;
		logic [ADDR_W-1:0] raddr;
	} st_req_t;

	typedef struct packed {
		logic lock_release;
		logic open_lamp;
		logic wrong_lamp;
		logic change_lamp;
		logic buzz_level;
		logic beep;
		logic asleep;
	} res_t;

	// Master digit at 1-based position; positions past the register read as zero.
	function automatic logic [3:0] master_digit(input logic [31:0] key, input logic [7:0] pos);
		logic [7:0] idx;
		idx = pos - 8'd1;
		if (pos == 8'd0 || pos > 8'd8)
			return 4'd0;
		return key[idx[2:0]*4 +: 4];
	endfunction

endpackage

@@ rtl/core/kcl_store.sv @@
// Password digit store with registered read and write-through bypass.
module kcl_store #(
	parameter int STORE_DEPTH = kcl_pkg::STORE_DEPTH_DEF
) (
	input  logic             clk,
	input  kcl_pkg::st_req_t req,
	output logic [3:0]       rd_digit
);
	import kcl_pkg::*;

	localparam int AW = $clog2(STORE_DEPTH);

	logic [3:0] mem [STORE_DEPTH];
	logic [3:0] rd_q;

	always_ff @(posedge clk) begin
		if (req.we)
			mem[req.waddr[AW-1:0]] <= req.wdata;
		if (req.we && req.waddr == req.raddr)
			rd_q <= req.wdata;
		else
			rd_q <= mem[req.raddr[AW-1:0]];
	end

	assign rd_digit = rd_q;

endmodule

@@ rtl/core/kcl_ctrl.sv @@
// Lock state, timers and the per-word update logic.
module kcl_ctrl #(
	parameter int STORE_DEPTH = kcl_pkg::STORE_DEPTH_DEF,
	parameter int MASTER_LEN  = kcl_pkg::MASTER_LEN_DEF
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             go,
	input  logic [1:0]       op,
	input  logic [3:0]       key,
	input  kcl_pkg::cfg_t    cfg,
	input  logic [3:0]       rd_digit,
	output kcl_pkg::st_req_t st_req,
	output kcl_pkg::res_t    res
);
	import kcl_pkg::*;

	localparam int LEN_W = $clog2(STORE_DEPTH + 1);
	localparam int EC_W  = $clog2(((STORE_DEPTH > MASTER_LEN) ? STORE_DEPTH : MASTER_LEN) + 2);

	logic [EC_W-1:0]  ec_q, ec_d;
	logic [LEN_W-1:0] len_q, len_d;
	logic [7:0]       cpc_q, cpc_d, wt_q, wt_d, bt_q, bt_d, rt_q, rt_d, il_q, il_d, ih_q, ih_d;
	logic             mis_q, mis_d, unl_q, unl_d, chg_q, chg_d, slp_q, slp_d, held_q, held_d;
	logic             lk_q, lk_d, lo_q, lo_d, lw_q, lw_d, lc_q, lc_d, bz_q, bz_d;
	logic             chirp;
	logic [3:0]       stored;

	always_comb begin
		ec_d = ec_q; len_d = len_q; cpc_d = cpc_q;
		wt_d = wt_q; bt_d = bt_q; rt_d = rt_q; il_d = il_q; ih_d = ih_q;
		mis_d = mis_q; unl_d = unl_q; chg_d = chg_q; slp_d = slp_q; held_d = held_q;
		lk_d = lk_q; lo_d = lo_q; lw_d = lw_q; lc_d = lc_q; bz_d = bz_q;
		chirp = 1'b0;
		stored = ERASED_DIGIT;
		st_req.we = 1'b0;
		st_req.waddr = ADDR_W'(len_q);
		st_req.wdata = key;
		if (go) begin
			if (op == OP_TICK) begin
				if (!slp_q) begin
					if (lw_d) begin
						wt_d = wt_d + 8'd1;
						if (wt_d >= cfg.wrong_ticks) begin
							lw_d = 1'b0; bz_d = 1'b0; wt_d = 8'd0;
						end
					end
					if (bz_d) begin
						if (!chg_d)
							bt_d = bt_d + 8'd1;
						if (bt_d >= cfg.buzzer_ticks) begin
							bz_d = 1'b0; bt_d = 8'd0;
						end
					end
					if (lk_d) begin
						rt_d = rt_d + 8'd1;
						if (rt_d >= cfg.lock_ticks) begin
							lk_d = 1'b0; lo_d = 1'b1; rt_d = 8'd0;
						end
					end
					if (!held_d)
						il_d = il_d + 8'd1;
					if (il_d == IDLE_LOW_MAX)
						ih_d = ih_d + 8'd1;
					// long idle: drop the entry and go to sleep
					if (ih_d >= cfg.idle_limit) begin
						ih_d = 8'd0; ec_d = '0; mis_d = 1'b0; cpc_d = 8'd0;
						lo_d = 1'b0; lw_d = 1'b0; bz_d = 1'b0; slp_d = 1'b1;
					end
				end
			end else if (op == OP_PRESS || op == OP_RELEASE) begin
				il_d = 8'd0;
				ih_d = 8'd0;
				if (slp_q) begin
					slp_d = 1'b0;
				end else if (op == OP_RELEASE) begin
					held_d = 1'b0;
				end else begin
					held_d = 1'b1;
					if (key < DIGIT_LIMIT) begin
						if (chg_q) begin
							if (len_q < LEN_W'(STORE_DEPTH)) begin
								st_req.we = 1'b1;
								len_d = len_q + LEN_W'(1);
								chirp = 1'b1;
							end
						end else if (!unl_q) begin
							if (!mis_q) begin
								// count never passes the larger of the store depth and the master length, plus one
								ec_d = ec_q + EC_W'(1);
								stored = (ec_d > EC_W'(len_q)) ? ERASED_DIGIT : rd_digit;
								if (stored != key) begin
									if (ec_d > EC_W'(MASTER_LEN) ||
									    key != master_digit(cfg.master_code, 8'(ec_d)))
										mis_d = 1'b1;
								end
							end
							chirp = 1'b1;
						end
					end else if (key == KEY_STAR) begin
						ec_d = '0;
						mis_d = 1'b0;
						if (unl_q) begin
							if (chg_q) begin
								chg_d = 1'b0; lc_d = 1'b0;
							end else begin
								cpc_d = cpc_q + 8'd1;
								if (cpc_d >= cfg.change_presses) begin
									cpc_d = 8'd0; chg_d = 1'b1; len_d = '0; lc_d = 1'b1;
								end
							end
							chirp = 1'b1;
						end
					end else if (key == KEY_HASH) begin
						if (!chg_q) begin
							if (unl_q) begin
								lk_d = 1'b0; unl_d = 1'b0; lo_d = 1'b0;
							end else if (!mis_q && (ec_q == EC_W'(len_q) ||
							                        ec_q == EC_W'(MASTER_LEN))) begin
								lw_d = 1'b0; lk_d = 1'b1; unl_d = 1'b1; rt_d = 8'd0;
							end else begin
								wt_d = 8'd0; lw_d = 1'b1; bz_d = 1'b1;
							end
							mis_d = 1'b0;
							ec_d = '0;
							cpc_d = 8'd0;
						end
					end
					if (chirp)
						bz_d = 1'b0;
				end
			end
		end
		// prefetch the digit the next press will compare against
		st_req.raddr = ADDR_W'(ec_d);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ec_q <= '0; len_q <= '0; cpc_q <= 8'd0;
			wt_q <= 8'd0; bt_q <= 8'd0; rt_q <= 8'd0; il_q <= 8'd0; ih_q <= 8'd0;
			mis_q <= 1'b0; unl_q <= 1'b0; chg_q <= 1'b0; slp_q <= 1'b0; held_q <= 1'b0;
			lk_q <= 1'b0; lo_q <= 1'b0; lw_q <= 1'b0; lc_q <= 1'b0; bz_q <= 1'b0;
		end else begin
			ec_q <= ec_d; len_q <= len_d; cpc_q <= cpc_d;
			wt_q <= wt_d; bt_q <= bt_d; rt_q <= rt_d; il_q <= il_d; ih_q <= ih_d;
			mis_q <= mis_d; unl_q <= unl_d; chg_q <= chg_d; slp_q <= slp_d; held_q <= held_d;
			lk_q <= lk_d; lo_q <= lo_d; lw_q <= lw_d; lc_q <= lc_d; bz_q <= bz_d;
		end
	end

	always_comb begin
		res.lock_release = lk_d;
		res.open_lamp    = lo_d;
		res.wrong_lamp   = lw_d;
		res.change_lamp  = lc_d;
		res.buzz_level   = bz_d;
		res.beep         = chirp;
		res.asleep       = slp_d;
	end

endmodule

@@ rtl/core/keypad_combination_lock_top.sv @@
// Keypad lock top level: config registers, input stage and result register.
// An accepted word is held in the input stage; its result is captured in the result
// register. Throughput: one word per cycle while out_ready is high;
// a stalled result holds the word in the input stage and in_ready drops.
// Reset clears all control state and the password length; the digit store is
// not swept, since an empty length masks every stored entry.
module keypad_combination_lock_top #(
	parameter int STORE_DEPTH = kcl_pkg::STORE_DEPTH_DEF,
	parameter int MASTER_LEN  = kcl_pkg::MASTER_LEN_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic [2:0]  cfg_index,
	input  logic [31:0] cfg_data,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [1:0]  operation,
	input  logic [3:0]  key_code,
	output logic        out_valid,
	input  logic        out_ready,
	output logic        lock_release,
	output logic        open_lamp,
	output logic        wrong_lamp,
	output logic        change_lamp,
	output logic        buzz_level,
	output logic        beep,
	output logic        asleep
);
	import kcl_pkg::*;

	cfg_t       cfg_q;
	logic       valid_s1;
	logic [1:0] op_s1;
	logic [3:0] key_s1;
	logic       out_valid_q;
	res_t       res_q;
	res_t       res;
	st_req_t    st_req;
	logic [3:0] rd_digit;
	logic       go;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.wrong_ticks    <= RST_WRONG_TICKS;
			cfg_q.buzzer_ticks   <= RST_BUZZ_TICKS;
			cfg_q.lock_ticks     <= RST_LOCK_TICKS;
			cfg_q.idle_limit     <= RST_IDLE_LIMIT;
			cfg_q.change_presses <= RST_CHG_PRESSES;
			cfg_q.master_code    <= RST_MASTER_CODE;
		end else if (cfg_we) begin
			unique case (cfg_index)
				CFG_WRONG_TICKS: cfg_q.wrong_ticks    <= cfg_data[7:0];
				CFG_BUZZ_TICKS:  cfg_q.buzzer_ticks   <= cfg_data[7:0];
				CFG_LOCK_TICKS:  cfg_q.lock_ticks     <= cfg_data[7:0];
				CFG_IDLE_LIMIT:  cfg_q.idle_limit     <= cfg_data[7:0];
				CFG_CHG_PRESSES: cfg_q.change_presses <= cfg_data[7:0];
				CFG_MASTER_CODE: cfg_q.master_code    <= cfg_data;
				default: ;
			endcase
		end
	end

	// advance the held word when the result slot is free or being drained
	assign go       = valid_s1 && (!out_valid_q || out_ready);
	assign in_ready = !valid_s1 || go;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1    <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (in_ready)
				valid_s1 <= in_valid;
			if (go)
				out_valid_q <= 1'b1;
			else if (out_ready)
				out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			op_s1  <= operation;
			key_s1 <= key_code;
		end
		if (go)
			res_q <= res;
	end

	kcl_ctrl #(
		.STORE_DEPTH(STORE_DEPTH),
		.MASTER_LEN (MASTER_LEN)
	) u_ctrl (
		.clk     (clk),
		.arst_n  (arst_n),
		.go      (go),
		.op      (op_s1),
		.key     (key_s1),
		.cfg     (cfg_q),
		.rd_digit(rd_digit),
		.st_req  (st_req),
		.res     (res)
	);

	kcl_store #(
		.STORE_DEPTH(STORE_DEPTH)
	) u_store (
		.clk     (clk),
		.req     (st_req),
		.rd_digit(rd_digit)
	);

	assign out_valid    = out_valid_q;
	assign lock_release = res_q.lock_release;
	assign open_lamp    = res_q.open_lamp;
	assign wrong_lamp   = res_q.wrong_lamp;
	assign change_lamp  = res_q.change_lamp;
	assign buzz_level   = res_q.buzz_level;
	assign beep         = res_q.beep;
	assign asleep       = res_q.asleep;

endmodule

@@ rtl/core/kcl_checker.sv @@
// Port-level checks for the keypad lock, bound to the top level.
module kcl_checker (
	input logic clk,
	input logic arst_n,
	input logic out_valid,
	input logic out_ready,
	input logic lock_release,
	input logic open_lamp,
	input logic wrong_lamp,
	input logic change_lamp,
	input logic buzz_level,
	input logic beep,
	input logic asleep
);

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid &&
		$stable({lock_release, open_lamp, wrong_lamp, change_lamp, buzz_level, beep, asleep}))
		else $error("result word changed while stalled");

	a_beep_quiet: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && beep |-> !buzz_level && !asleep)
		else $error("chirp with buzzer on or while asleep");

	a_sleep_dark: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && asleep |-> !open_lamp && !wrong_lamp && !buzz_level)
		else $error("indicator lit while asleep");

	a_open_not_wrong: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && lock_release |-> !wrong_lamp)
		else $error("wrong LED lit while lock released");

endmodule

bind keypad_combination_lock_top kcl_checker u_kcl_checker (.*);
